>>> hdl/sorted_leaf_table_unit_defines.svh
// Assertion macros of the sorted leaf table RTL.
`ifndef SORTED_LEAF_TABLE_UNIT_DEFINES_SVH
`define SORTED_LEAF_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication on i_clk, checked out of reset.
`define SLT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication on i_clk, checked out of reset.
`define SLT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SLT_ASSERT_NOW(lbl, ante, cons, msg)
`define SLT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hdl/slt_pkg.sv
// Types and codes of the sorted leaf table.
package slt_pkg;

    // Operation codes carried by an item
    typedef enum logic [2:0] {
        OP_FIND   = 3'd0,
        OP_INSERT = 3'd1,
        OP_UPDATE = 3'd2,
        OP_UPSERT = 3'd3,
        OP_SPLIT  = 3'd4
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_MISS    = 2'd1,
        STS_FULL    = 2'd2,
        STS_NOSPLIT = 2'd3
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SPLIT
    } t_state;

    // What a cell loads at the next edge
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_UP,
        CELL_DOWN,
        CELL_LOAD,
        CELL_SETVAL
    } t_cell_op;

    localparam int KeyW = 32;
    localparam int ValW = 32;

endpackage

>>> hdl/slt_cell.sv
// One entry of the sorted table: key/value storage plus its comparator.
module slt_cell (
    input  logic                            i_clk,
    input  slt_pkg::t_cell_op               i_op,
    input  logic signed [slt_pkg::KeyW-1:0] i_lo_key,
    input  logic signed [slt_pkg::ValW-1:0] i_lo_val,
    input  logic signed [slt_pkg::KeyW-1:0] i_hi_key,
    input  logic signed [slt_pkg::ValW-1:0] i_hi_val,
    input  logic signed [slt_pkg::KeyW-1:0] i_new_key,
    input  logic signed [slt_pkg::ValW-1:0] i_new_val,
    output logic signed [slt_pkg::KeyW-1:0] o_key,
    output logic signed [slt_pkg::ValW-1:0] o_val,
    output logic                            o_lt,
    output logic                            o_eq
);

    logic signed [slt_pkg::KeyW-1:0] r_key, n_key;
    logic signed [slt_pkg::ValW-1:0] r_val, n_val;

    // Next entry: hold, take a neighbor, take the new item, or take only the new value
    always_comb begin
        n_key = r_key;
        n_val = r_val;
        unique case (i_op)
            slt_pkg::CELL_HOLD: begin
            end
            slt_pkg::CELL_UP: begin
                n_key = i_lo_key;
                n_val = i_lo_val;
            end
            slt_pkg::CELL_DOWN: begin
                n_key = i_hi_key;
                n_val = i_hi_val;
            end
            slt_pkg::CELL_LOAD: begin
                n_key = i_new_key;
                n_val = i_new_val;
            end
            slt_pkg::CELL_SETVAL: begin
                n_val = i_new_val;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_val <= n_val;
    end

    // Signed compare against the search key
    assign o_lt  = (r_key < i_new_key);
    assign o_eq  = (r_key == i_new_key);
    assign o_key = r_key;
    assign o_val = r_val;

endmodule

>>> hdl/sorted_leaf_table_unit.sv
// Sorted leaf table: takes one item at a time and holds busy high until its result strobes.
// Each find, insert, update or upsert is one compare-and-shift pass over the row of CAPACITY cells.
// Split of a full table keeps busy high while it streams CAPACITY-CAPACITY/2-1 results,
// one per cycle, taken from the cell above the separator.
// Synchronous active-low reset empties the table, idles the controller and drops the strobe.
// Results cannot be stalled; the next item may be accepted while a result is shown.
`include "sorted_leaf_table_unit_defines.svh"

module sorted_leaf_table_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [2:0]                           i_op,
    input  logic signed [slt_pkg::KeyW-1:0]      i_key,
    input  logic signed [slt_pkg::ValW-1:0]      i_value,
    output logic                                 o_valid,
    output logic [1:0]                           o_status,
    output logic                                 o_found,
    output logic [$clog2(CAPACITY+1)-1:0]        o_position,
    output logic signed [slt_pkg::KeyW-1:0]      o_key_out,
    output logic signed [slt_pkg::ValW-1:0]      o_value_out,
    output logic signed [slt_pkg::KeyW-1:0]      o_separator,
    output logic [$clog2(CAPACITY+1)-1:0]        o_entries_after,
    output logic                                 o_last
);

    localparam int CW      = $clog2(CAPACITY + 1);
    localparam int IW      = $clog2(CAPACITY);
    localparam int SEP_POS = CAPACITY / 2;
    localparam int KEEP    = SEP_POS + 1;

    // Controller and command registers
    slt_pkg::t_state                  r_state, n_state;
    slt_pkg::t_op                     r_op;
    logic signed [slt_pkg::KeyW-1:0]  r_key;
    logic signed [slt_pkg::ValW-1:0]  r_val;
    logic [CW-1:0]                    r_count, n_count;
    logic [IW-1:0]                    r_idx, n_idx;

    // Result registers
    logic                             r_valid, n_valid;
    slt_pkg::t_status                 r_status, n_status;
    logic                             r_found, n_found;
    logic [CW-1:0]                    r_position, n_position;
    logic signed [slt_pkg::KeyW-1:0]  r_key_out, n_key_out;
    logic signed [slt_pkg::ValW-1:0]  r_value_out, n_value_out;
    logic signed [slt_pkg::KeyW-1:0]  r_separator, n_separator;
    logic [CW-1:0]                    r_entries, n_entries;
    logic                             r_last, n_last;

    // Cell row signals
    slt_pkg::t_cell_op                cell_op  [CAPACITY];
    logic signed [slt_pkg::KeyW-1:0]  cell_key [CAPACITY];
    logic signed [slt_pkg::ValW-1:0]  cell_val [CAPACITY];
    logic [CAPACITY-1:0]              cell_lt, cell_eq, occ, below;
    logic [CAPACITY:0]                edge_pt;

    logic [CW-1:0]                    pos;
    logic                             hit;
    logic signed [slt_pkg::ValW-1:0]  old_val;
    logic                             full;
    logic                             do_insert, do_update;
    logic                             in_split, split_tail;

    // Split drain and its final entry
    assign in_split   = (r_state == slt_pkg::ST_SPLIT);
    assign split_tail = in_split && (r_idx == IW'(CAPACITY - 1));

    // Row of cells, each wired to its neighbors; an end cell takes itself on its open side
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam int LO = (i == 0) ? 0 : i - 1;
        localparam int HI = (i == CAPACITY - 1) ? i : i + 1;

        slt_cell u_cell (
            .i_clk     (i_clk),
            .i_op      (cell_op[i]),
            .i_lo_key  (cell_key[LO]),
            .i_lo_val  (cell_val[LO]),
            .i_hi_key  (cell_key[HI]),
            .i_hi_val  (cell_val[HI]),
            .i_new_key (r_key),
            .i_new_val (r_val),
            .o_key     (cell_key[i]),
            .o_val     (cell_val[i]),
            .o_lt      (cell_lt[i]),
            .o_eq      (cell_eq[i])
        );

        assign occ[i]   = (CW'(i) < r_count);
        assign below[i] = occ[i] & cell_lt[i];

        // Cell control: insert opens a gap at the lower bound, update rewrites the value there, split slides down
        always_comb begin
            cell_op[i] = slt_pkg::CELL_HOLD;
            if (in_split) begin
                if (i >= KEEP) begin
                    cell_op[i] = slt_pkg::CELL_DOWN;
                end
            end else if (do_insert) begin
                if (edge_pt[i]) begin
                    cell_op[i] = slt_pkg::CELL_LOAD;
                end else if (!below[i]) begin
                    cell_op[i] = slt_pkg::CELL_UP;
                end
            end else if (do_update && edge_pt[i]) begin
                cell_op[i] = slt_pkg::CELL_SETVAL;
            end
        end
    end

    // Lower bound: the one place where the "below" prefix ends
    for (genvar i = 0; i <= CAPACITY; i++) begin : g_edge
        localparam bit FIRST = (i == 0);
        localparam bit LASTC = (i == CAPACITY);
        if (FIRST && LASTC) begin : g_both
            assign edge_pt[i] = 1'b1;
        end else if (FIRST) begin : g_first
            assign edge_pt[i] = !below[i];
        end else if (LASTC) begin : g_top
            assign edge_pt[i] = below[i-1];
        end else begin : g_mid
            assign edge_pt[i] = below[i-1] & !below[i];
        end
    end

    // One-hot to binary position, match flag and stored value
    always_comb begin
        pos     = '0;
        hit     = 1'b0;
        old_val = '0;
        for (int i = 0; i <= CAPACITY; i++) begin
            if (edge_pt[i]) begin
                pos = pos | CW'(i);
            end
        end
        for (int i = 0; i < CAPACITY; i++) begin
            if (edge_pt[i] && occ[i] && cell_eq[i]) begin
                hit     = 1'b1;
                old_val = old_val | cell_val[i];
            end
        end
    end

    assign full = (r_count == CW'(CAPACITY));

    // Next state and result
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_valid     = 1'b0;
        n_status    = slt_pkg::STS_OK;
        n_found     = 1'b0;
        n_position  = '0;
        n_key_out   = '0;
        n_value_out = '0;
        n_separator = '0;
        n_entries   = r_count;
        n_last      = 1'b0;
        do_insert   = 1'b0;
        do_update   = 1'b0;
        unique case (r_state)
            slt_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = slt_pkg::ST_EXEC;
                end
            end
            slt_pkg::ST_EXEC: begin
                n_state     = slt_pkg::ST_IDLE;
                n_valid     = 1'b1;
                n_last      = 1'b1;
                n_found     = hit;
                n_position  = pos;
                n_value_out = old_val;
                unique case (r_op)
                    slt_pkg::OP_INSERT: begin
                        if (full) begin
                            n_status = slt_pkg::STS_FULL;
                        end else begin
                            do_insert = 1'b1;
                        end
                    end
                    slt_pkg::OP_UPDATE: begin
                        if (hit) begin
                            do_update = 1'b1;
                        end else begin
                            n_status = slt_pkg::STS_MISS;
                        end
                    end
                    slt_pkg::OP_UPSERT: begin
                        if (hit) begin
                            do_update = 1'b1;
                        end else if (full) begin
                            n_status = slt_pkg::STS_FULL;
                        end else begin
                            do_insert = 1'b1;
                        end
                    end
                    slt_pkg::OP_SPLIT: begin
                        n_found     = 1'b0;
                        n_position  = '0;
                        n_value_out = '0;
                        if (!full) begin
                            n_status = slt_pkg::STS_NOSPLIT;
                        end else begin
                            n_valid = 1'b0;
                            n_last  = 1'b0;
                            n_state = slt_pkg::ST_SPLIT;
                            n_idx   = IW'(KEEP);
                            n_count = CW'(KEEP);
                        end
                    end
                    default: begin
                        n_status = hit ? slt_pkg::STS_OK : slt_pkg::STS_MISS;
                    end
                endcase
                if (do_insert) begin
                    n_count = r_count + 1'b1;
                end
                n_entries = do_insert ? r_count + 1'b1 : r_count;
            end
            slt_pkg::ST_SPLIT: begin
                // Emit the entry sitting just above the separator
                n_valid     = 1'b1;
                n_position  = CW'(r_idx);
                n_key_out   = cell_key[KEEP];
                n_value_out = cell_val[KEEP];
                n_separator = cell_key[SEP_POS];
                n_entries   = r_count;
                n_last      = split_tail;
                if (n_last) begin
                    n_state = slt_pkg::ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = slt_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slt_pkg::ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // Command capture and result payload
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op  <= slt_pkg::t_op'(i_op);
            r_key <= i_key;
            r_val <= i_value;
        end
        r_idx       <= n_idx;
        r_status    <= n_status;
        r_found     <= n_found;
        r_position  <= n_position;
        r_key_out   <= n_key_out;
        r_value_out <= n_value_out;
        r_separator <= n_separator;
        r_entries   <= n_entries;
        r_last      <= n_last;
    end

    assign busy            = (r_state != slt_pkg::ST_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_found         = r_found;
    assign o_position      = r_position;
    assign o_key_out       = r_key_out;
    assign o_value_out     = r_value_out;
    assign o_separator     = r_separator;
    assign o_entries_after = r_entries;
    assign o_last          = r_last;

    // Checks
    `SLT_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(CAPACITY), "count overflow")
    `SLT_ASSERT_NEXT(a_idle_quiet, !busy, !o_valid, "stray result")
    `SLT_ASSERT_NEXT(a_accept_exec, start && !busy, r_state == slt_pkg::ST_EXEC, "item lost")
    `SLT_ASSERT_NEXT(a_split_end, split_tail, !busy && o_valid && o_last, "split did not close")
    `SLT_ASSERT_NOW(a_split_count, in_split, r_count == CW'(KEEP), "split count wrong")

endmodule

>>> verif/testbench.sv
// Self-checking testbench of the sorted leaf table: directed rows, then count-aware random items.
`timescale 1ns / 100ps

module testbench;

    localparam int CAP        = 64;
    localparam int N_DIR      = 21;
    localparam int N_RANDOM   = 320;
    localparam int STALL_MAX  = 1000;
    localparam int TAIL_WAIT  = 8;

    // Codes outside the operation set; the block treats them as find
    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        slt_pkg::t_status   status;
        logic               found;
        logic [6:0]         position;
        logic signed [31:0] key_out;
        logic signed [31:0] value_out;
        logic signed [31:0] separator;
        logic [6:0]         entries_after;
        logic               last;
    } t_leaf_result;

    // Directed row: item fields and its result; known rows check the typed result
    typedef struct packed {
        logic               known;
        logic [2:0]         op;
        logic signed [31:0] key;
        logic signed [31:0] value;
        slt_pkg::t_status   status;
        logic               found;
        logic [6:0]         position;
        logic signed [31:0] value_out;
        logic [6:0]         entries;
    } t_leaf_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         i_op;
    logic signed [31:0] i_key;
    logic signed [31:0] i_value;
    logic               o_valid;
    logic [1:0]         o_status;
    logic               o_found;
    logic [6:0]         o_position;
    logic signed [31:0] o_key_out;
    logic signed [31:0] o_value_out;
    logic signed [31:0] o_separator;
    logic [6:0]         o_entries_after;
    logic               o_last;

    // Shadow copy of the table
    logic signed [31:0] tbl_key [CAP];
    logic signed [31:0] tbl_val [CAP];
    int                 tbl_count;

    t_leaf_result       leaf_expect [$];
    int                 leaf_errors;
    int                 n_items;
    int                 n_results;
    int                 n_splits;
    int                 n_refused;
    int                 stall_cycles;
    bit                 idle_on;

    // Empty table first, then extremes, duplicates, every op and the reserved codes
    t_leaf_row dir_rows [N_DIR] = '{
        '{1'b1, slt_pkg::OP_FIND, 32'sd0, 32'sd0,
          slt_pkg::STS_MISS, 1'b0, 7'd0, 32'sd0, 7'd0},
        '{1'b1, slt_pkg::OP_SPLIT, 32'sd0, 32'sd0,
          slt_pkg::STS_NOSPLIT, 1'b0, 7'd0, 32'sd0, 7'd0},
        '{1'b1, slt_pkg::OP_UPDATE, 32'sd5, 32'sd1,
          slt_pkg::STS_MISS, 1'b0, 7'd0, 32'sd0, 7'd0},
        '{1'b1, slt_pkg::OP_INSERT, KEY_MAX, KEY_MIN,
          slt_pkg::STS_OK, 1'b0, 7'd0, 32'sd0, 7'd1},
        '{1'b1, slt_pkg::OP_INSERT, KEY_MIN, KEY_MAX,
          slt_pkg::STS_OK, 1'b0, 7'd0, 32'sd0, 7'd2},
        '{1'b1, slt_pkg::OP_FIND, KEY_MAX, 32'sd0,
          slt_pkg::STS_OK, 1'b1, 7'd1, KEY_MIN, 7'd2},
        '{1'b1, slt_pkg::OP_FIND, KEY_MIN, 32'sd0,
          slt_pkg::STS_OK, 1'b1, 7'd0, KEY_MAX, 7'd2},
        '{1'b1, slt_pkg::OP_FIND, 32'sd0, 32'sd0,
          slt_pkg::STS_MISS, 1'b0, 7'd1, 32'sd0, 7'd2},
        '{1'b0, slt_pkg::OP_INSERT, 32'sd0, 32'shffff_ffff,
          slt_pkg::STS_OK, 1'b0, 7'd1, 32'sd0, 7'd3},
        '{1'b0, slt_pkg::OP_INSERT, 32'sd0, 32'sh1234_5678,
          slt_pkg::STS_OK, 1'b1, 7'd1, 32'shffff_ffff, 7'd4},
        '{1'b0, slt_pkg::OP_FIND, 32'sd0, 32'sd0,
          slt_pkg::STS_OK, 1'b1, 7'd1, 32'sh1234_5678, 7'd4},
        '{1'b0, slt_pkg::OP_UPDATE, 32'sd0, 32'shaaaa_5555,
          slt_pkg::STS_OK, 1'b1, 7'd1, 32'sh1234_5678, 7'd4},
        '{1'b1, slt_pkg::OP_UPDATE, -32'sd1, 32'sd3,
          slt_pkg::STS_MISS, 1'b0, 7'd1, 32'sd0, 7'd4},
        '{1'b0, slt_pkg::OP_UPSERT, 32'sd0, 32'sh5555_aaaa,
          slt_pkg::STS_OK, 1'b1, 7'd1, 32'shaaaa_5555, 7'd4},
        '{1'b0, slt_pkg::OP_UPSERT, -32'sd1, 32'sh0f0f_0f0f,
          slt_pkg::STS_OK, 1'b0, 7'd1, 32'sd0, 7'd5},
        '{1'b0, OP_RSVD5, -32'sd1, 32'sd0,
          slt_pkg::STS_OK, 1'b1, 7'd1, 32'sh0f0f_0f0f, 7'd5},
        '{1'b1, OP_RSVD6, 32'sd7, 32'sd0,
          slt_pkg::STS_MISS, 1'b0, 7'd4, 32'sd0, 7'd5},
        '{1'b0, OP_RSVD7, KEY_MAX, 32'sd0,
          slt_pkg::STS_OK, 1'b1, 7'd4, KEY_MIN, 7'd5},
        '{1'b1, slt_pkg::OP_SPLIT, 32'sd0, 32'sd0,
          slt_pkg::STS_NOSPLIT, 1'b0, 7'd0, 32'sd0, 7'd5},
        '{1'b0, slt_pkg::OP_INSERT, KEY_MAX, 32'sd0,
          slt_pkg::STS_OK, 1'b1, 7'd4, KEY_MIN, 7'd6},
        '{1'b1, slt_pkg::OP_FIND, 32'sh8000_0001, 32'sd0,
          slt_pkg::STS_MISS, 1'b0, 7'd1, 32'sd0, 7'd6}
    };

    sorted_leaf_table_unit #(
        .CAPACITY(CAP)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_key          (i_key),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_found        (o_found),
        .o_position     (o_position),
        .o_key_out      (o_key_out),
        .o_value_out    (o_value_out),
        .o_separator    (o_separator),
        .o_entries_after(o_entries_after),
        .o_last         (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Open a slot at pos and store the pair there
    function automatic void shift_in(int pos, logic signed [31:0] k, logic signed [31:0] v);
        for (int i = tbl_count; i > pos; i--) begin
            tbl_key[i] = tbl_key[i-1];
            tbl_val[i] = tbl_val[i-1];
        end
        tbl_key[pos] = k;
        tbl_val[pos] = v;
        tbl_count++;
    endfunction

    // Apply one item to the shadow table and queue the results it must give
    function automatic void predict_leaf(logic [2:0] op, logic signed [31:0] k,
                                         logic signed [31:0] v);
        int                 pos;
        bit                 hit;
        bit                 full;
        logic signed [31:0] old;
        t_leaf_result       r;
        pos = 0;
        while (pos < tbl_count && tbl_key[pos] < k) pos++;
        hit  = (pos < tbl_count) && (tbl_key[pos] == k);
        old  = hit ? tbl_val[pos] : 32'sd0;
        full = (tbl_count >= CAP);
        r    = '0;
        r.last = 1'b1;
        if (op == slt_pkg::OP_SPLIT) begin
            if (!full) begin
                r.status        = slt_pkg::STS_NOSPLIT;
                r.entries_after = tbl_count[6:0];
                leaf_expect.push_back(r);
                return;
            end
            // Keep entries up to the middle; stream the rest out in order
            for (int i = CAP / 2 + 1; i < CAP; i++) begin
                r.status        = slt_pkg::STS_OK;
                r.position      = i[6:0];
                r.key_out       = tbl_key[i];
                r.value_out     = tbl_val[i];
                r.separator     = tbl_key[CAP/2];
                r.entries_after = 7'(CAP / 2 + 1);
                r.last          = (i == CAP - 1);
                leaf_expect.push_back(r);
            end
            tbl_count = CAP / 2 + 1;
            n_splits++;
            return;
        end
        r.status = slt_pkg::STS_OK;
        case (op)
            slt_pkg::OP_INSERT: begin
                if (full) r.status = slt_pkg::STS_FULL;
                else shift_in(pos, k, v);
            end
            slt_pkg::OP_UPDATE: begin
                if (hit) tbl_val[pos] = v;
                else r.status = slt_pkg::STS_MISS;
            end
            slt_pkg::OP_UPSERT: begin
                if (hit) tbl_val[pos] = v;
                else if (full) r.status = slt_pkg::STS_FULL;
                else shift_in(pos, k, v);
            end
            default: begin
                r.status = hit ? slt_pkg::STS_OK : slt_pkg::STS_MISS;
            end
        endcase
        if (r.status == slt_pkg::STS_FULL) n_refused++;
        r.found         = hit;
        r.position      = pos[6:0];
        r.value_out     = old;
        r.entries_after = tbl_count[6:0];
        leaf_expect.push_back(r);
    endfunction

    // Mostly stored keys and a narrow band, so finds hit and duplicates form
    function automatic logic signed [31:0] pick_key();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40 && tbl_count > 0) return tbl_key[$urandom_range(0, tbl_count - 1)];
        if (sel < 60) return $signed(32'($urandom_range(0, 16))) - 32'sd8;
        if (sel < 70) begin
            case ($urandom_range(0, 3))
                0:       return KEY_MIN;
                1:       return KEY_MAX;
                2:       return -32'sd1;
                default: return 32'sd0;
            endcase
        end
        return $urandom;
    endfunction

    // Split is likely once full; otherwise the mix grows the table
    function automatic logic [2:0] pick_op();
        int sel;
        sel = $urandom_range(0, 99);
        if (tbl_count >= CAP) begin
            if (sel < 35) return slt_pkg::OP_SPLIT;
            if (sel < 55) return slt_pkg::OP_INSERT;
            if (sel < 65) return slt_pkg::OP_UPSERT;
            if (sel < 80) return slt_pkg::OP_FIND;
            if (sel < 92) return slt_pkg::OP_UPDATE;
        end else begin
            if (sel < 47) return slt_pkg::OP_INSERT;
            if (sel < 62) return slt_pkg::OP_UPSERT;
            if (sel < 74) return slt_pkg::OP_FIND;
            if (sel < 86) return slt_pkg::OP_UPDATE;
            if (sel < 92) return slt_pkg::OP_SPLIT;
        end
        return 3'($urandom_range(OP_RSVD5, OP_RSVD7));
    endfunction

    // Present one item, after a random gap when idling is on, and hold it until taken
    task automatic send_item(input logic [2:0] op, input logic signed [31:0] k,
                             input logic signed [31:0] v);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start   <= 1'b1;
        i_op    <= op;
        i_key   <= k;
        i_value <= v;
        do @(posedge i_clk); while (busy);
        predict_leaf(op, k, v);
        n_items++;
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            leaf_errors++;
        end
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_leaf_result want;
        if (i_rst_n && o_valid) begin
            n_results++;
            if (leaf_expect.size() == 0) begin
                $error("result with no item pending: status %0h position %0d",
                       o_status, o_position);
                leaf_errors++;
            end else begin
                want = leaf_expect.pop_front();
                check_field("status", want.status, o_status);
                check_field("found", want.found, o_found);
                check_field("position", want.position, o_position);
                check_field("key_out", want.key_out, o_key_out);
                check_field("value_out", want.value_out, o_value_out);
                check_field("separator", want.separator, o_separator);
                check_field("entries_after", want.entries_after, o_entries_after);
                check_field("last", want.last, o_last);
            end
        end
    end

    // Watchdog on cycles with neither an item taken nor a result shown
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_MAX) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        t_leaf_result typed;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_op        = slt_pkg::OP_FIND;
        i_key       = '0;
        i_value     = '0;
        tbl_count   = 0;
        leaf_errors = 0;
        n_items     = 0;
        n_results   = 0;
        n_splits    = 0;
        n_refused   = 0;
        idle_on     = 1'b1;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Known rows carry their own expected result; the rest use the predictor
        foreach (dir_rows[n]) begin
            send_item(dir_rows[n].op, dir_rows[n].key, dir_rows[n].value);
            if (dir_rows[n].known) begin
                typed               = '0;
                typed.status        = dir_rows[n].status;
                typed.found         = dir_rows[n].found;
                typed.position      = dir_rows[n].position;
                typed.value_out     = dir_rows[n].value_out;
                typed.entries_after = dir_rows[n].entries;
                typed.last          = 1'b1;
                void'(leaf_expect.pop_back());
                leaf_expect.push_back(typed);
            end
        end

        // Random items; idling switches on and off in stretches
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
            send_item(pick_op(), pick_key(), $urandom);
        end
        @(negedge i_clk);
        start <= 1'b0;

        while (leaf_expect.size() > 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("Run covered %0d items and %0d results: %0d splits, %0d refused when full.",
                 n_items, n_results, n_splits, n_refused);
        if (leaf_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
